// ===== hdl/triangle_tangent_basis_unit_defines.svh =====
`ifndef TRIANGLE_TANGENT_BASIS_UNIT_DEFINES_SVH
`define TRIANGLE_TANGENT_BASIS_UNIT_DEFINES_SVH

// Checks an expression at every rising edge of clk while rst_n is high.
`define TTB_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks an implication at every rising edge of clk while rst_n is high.
`define TTB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/ttb_pkg.sv =====
package ttb_pkg;
  localparam int POS_W   = 24;
  localparam int TEX_W   = 20;
  localparam int DP_W    = 25;
  localparam int DT_W    = 21;
  localparam int PROD_W  = 46;
  localparam int NUM_W   = 47;
  localparam int DET_W   = 43;
  localparam int OUT_W   = 32;
  localparam int QB_W    = 35;
  localparam int NCOMP   = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DLOAD,
    ST_DIV,
    ST_DFIN
  } ttb_state_t;
endpackage

// ===== hdl/triangle_tangent_basis_unit.sv =====
// After the third vertex of a triangle, the block runs its product schedule (ST_MUL) and,
// unless the UV determinant is zero, then divides each component (ST_DLOAD, ST_DIV, ST_DFIN).
// Throughput: one vertex per cycle for the first two vertices of a triangle while the
// sequencer is idle; the third holds the block until its result word is formed, using one
// shared 25x21 multiplier and a restoring divider (one quotient bit per cycle, six components).
// Reset (rst_n, synchronous, active low) clears held vertices, slot, state and valid.
`include "triangle_tangent_basis_unit_defines.svh"

module triangle_tangent_basis_unit
  import ttb_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic signed [TEX_W-1:0] in_tex_u,
  input  logic signed [TEX_W-1:0] in_tex_v,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_tangent_x,
  output logic signed [OUT_W-1:0] out_tangent_y,
  output logic signed [OUT_W-1:0] out_tangent_z,
  output logic signed [OUT_W-1:0] out_bitangent_x,
  output logic signed [OUT_W-1:0] out_bitangent_y,
  output logic signed [OUT_W-1:0] out_bitangent_z,
  output logic                    out_degenerate
);
  localparam int NW    = NUM_W + FRAC_BITS + 1;
  localparam int CNT_W = $clog2(NW);

  ttb_state_t st_r, st_nxt;

  logic                     en_r;
  logic [1:0]               slot_r;
  logic signed [POS_W-1:0]  p0_r [3];
  logic signed [POS_W-1:0]  p1_r [3];
  logic signed [TEX_W-1:0]  u0_r, v0_r, u1_r, v1_r;
  logic signed [DP_W-1:0]   dp1_r [3];
  logic signed [DP_W-1:0]   dp2_r [3];
  logic signed [DT_W-1:0]   du1_r, dv1_r, du2_r, dv2_r;
  logic [4:0]               mi_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [NUM_W-1:0]  acc_r;
  logic signed [DET_W-1:0]  det_r;
  logic [DET_W-1:0]         dmag_r;
  logic signed [NUM_W-1:0]  num_r [NCOMP];
  logic [2:0]               ci_r;
  logic [NW-1:0]            dvd_r;
  logic [DET_W-1:0]         rem_r;
  logic [QB_W-1:0]          q_r;
  logic                     ovf_r;
  logic                     neg_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [OUT_W-1:0]  res_r [NCOMP];
  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  out_t_r [3];
  logic signed [OUT_W-1:0]  out_b_r [3];
  logic                     out_deg_r;

  logic in_acc, closing, last_mul, last_comp;
  logic [3:0] pj;
  logic [3:0] pc;
  logic [1:0] pk;
  logic signed [DP_W-1:0] op_a;
  logic signed [DT_W-1:0] op_b;
  logic signed [NUM_W-1:0] prod_ext, diff;
  logic [3:0] nidx_w;

  assign in_ready  = (st_r == ST_IDLE) && !(slot_r[1] && out_valid_r);
  assign in_acc    = in_valid && in_ready;
  assign closing   = in_acc && slot_r[1];
  assign last_mul  = (mi_r == 5'd27);
  assign last_comp = (ci_r == 3'(NCOMP - 1));

  // Product schedule: j = 0,1 form det; then four products per axis.
  assign pj = mi_r[4:1];
  assign pc = pj - 4'd2;
  assign pk = pc[3:2];
  always_comb begin
    op_a = DP_W'(du1_r);
    op_b = dv2_r;
    if (pj == 4'd1) begin
      op_a = DP_W'(dv1_r);
      op_b = du2_r;
    end else if (pj != 4'd0) begin
      case (pc[1:0])
        2'd0: begin op_a = dp1_r[pk]; op_b = dv2_r; end
        2'd1: begin op_a = dp2_r[pk]; op_b = dv1_r; end
        2'd2: begin op_a = dp2_r[pk]; op_b = du1_r; end
        default: begin op_a = dp1_r[pk]; op_b = du2_r; end
      endcase
    end
  end

  assign prod_ext = NUM_W'(prod_r);
  assign diff     = acc_r - prod_ext;
  assign nidx_w   = (pj - 4'd3) >> 1;

  // Divider step and finishing logic.
  logic [DET_W:0]   trial, trial_sub;
  logic             ge;
  logic [NUM_W-1:0] nmag;
  logic [QB_W:0]    rsum;
  logic [QB_W-1:0]  rnd, lim, mag;
  logic [OUT_W-1:0] mag32;

  assign trial     = {rem_r, dvd_r[NW-1]};
  assign ge        = trial >= {1'b0, dmag_r};
  assign trial_sub = trial - {1'b0, dmag_r};
  assign nmag      = num_r[ci_r][NUM_W-1] ? NUM_W'(-num_r[ci_r]) : num_r[ci_r];
  assign rsum      = {1'b0, q_r} + (QB_W+1)'(1);
  assign rnd       = rsum[QB_W:1];
  assign lim       = neg_r ? QB_W'(34'h080000000) : QB_W'(34'h07FFFFFFF);
  assign mag       = (ovf_r || rnd > lim) ? lim : rnd;
  assign mag32     = mag[OUT_W-1:0];

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (closing && en_r) st_nxt = ST_MUL;
      ST_MUL:   if (last_mul) st_nxt = (det_r == '0) ? ST_IDLE : ST_DLOAD;
      ST_DLOAD: st_nxt = ST_DIV;
      ST_DIV:   if (cnt_r == CNT_W'(NW - 1)) st_nxt = ST_DFIN;
      ST_DFIN:  st_nxt = last_comp ? ST_IDLE : ST_DLOAD;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b1;
      slot_r      <= 2'd0;
      out_valid_r <= 1'b0;
      mi_r        <= '0;
      ci_r        <= '0;
      cnt_r       <= '0;
      for (int i = 0; i < 3; i++) begin
        p0_r[i] <= '0;
        p1_r[i] <= '0;
      end
      u0_r <= '0; v0_r <= '0; u1_r <= '0; v1_r <= '0;
    end else begin
      if (cfg_wr_en) en_r <= cfg_wr_data;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      if (in_acc) begin
        if (!slot_r[1]) begin
          slot_r <= slot_r + 2'd1;
          if (slot_r == 2'd0) begin
            p0_r[0] <= in_pos_x; p0_r[1] <= in_pos_y; p0_r[2] <= in_pos_z;
            u0_r <= in_tex_u; v0_r <= in_tex_v;
          end else begin
            p1_r[0] <= in_pos_x; p1_r[1] <= in_pos_y; p1_r[2] <= in_pos_z;
            u1_r <= in_tex_u; v1_r <= in_tex_v;
          end
        end else begin
          slot_r   <= 2'd0;
          mi_r     <= '0;
          dp1_r[0] <= DP_W'(p1_r[0]) - DP_W'(p0_r[0]);
          dp1_r[1] <= DP_W'(p1_r[1]) - DP_W'(p0_r[1]);
          dp1_r[2] <= DP_W'(p1_r[2]) - DP_W'(p0_r[2]);
          dp2_r[0] <= DP_W'(in_pos_x) - DP_W'(p0_r[0]);
          dp2_r[1] <= DP_W'(in_pos_y) - DP_W'(p0_r[1]);
          dp2_r[2] <= DP_W'(in_pos_z) - DP_W'(p0_r[2]);
          du1_r    <= DT_W'(u1_r) - DT_W'(u0_r);
          dv1_r    <= DT_W'(v1_r) - DT_W'(v0_r);
          du2_r    <= DT_W'(in_tex_u) - DT_W'(u0_r);
          dv2_r    <= DT_W'(in_tex_v) - DT_W'(v0_r);
        end
      end

      case (st_r)
        ST_MUL: begin
          mi_r <= mi_r + 5'd1;
          if (!mi_r[0]) begin
            prod_r <= op_a * op_b;
          end else if (!pj[0]) begin
            acc_r <= prod_ext;
          end else if (pj == 4'd1) begin
            det_r  <= diff[DET_W-1:0];
            dmag_r <= diff[DET_W-1] ? DET_W'(-diff[DET_W-1:0]) : diff[DET_W-1:0];
          end else begin
            num_r[nidx_w[2:0]] <= diff;
          end
          if (last_mul) begin
            ci_r <= '0;
            if (det_r == '0) begin
              out_valid_r <= 1'b1;
              out_deg_r   <= 1'b1;
              for (int i = 0; i < 3; i++) begin
                out_t_r[i] <= '0;
                out_b_r[i] <= '0;
              end
            end
          end
        end
        ST_DLOAD: begin
          dvd_r <= {nmag, (FRAC_BITS+1)'(0)};
          rem_r <= '0;
          q_r   <= '0;
          ovf_r <= 1'b0;
          neg_r <= num_r[ci_r][NUM_W-1] ^ det_r[DET_W-1];
          cnt_r <= '0;
        end
        ST_DIV: begin
          dvd_r <= dvd_r << 1;
          rem_r <= ge ? trial_sub[DET_W-1:0] : trial[DET_W-1:0];
          q_r   <= {q_r[QB_W-2:0], ge};
          ovf_r <= ovf_r | q_r[QB_W-1];
          cnt_r <= cnt_r + CNT_W'(1);
        end
        ST_DFIN: begin
          res_r[ci_r] <= neg_r ? -mag32 : mag32;
          ci_r <= ci_r + 3'd1;
          if (last_comp) begin
            out_valid_r <= 1'b1;
            out_deg_r   <= 1'b0;
            out_t_r[0]  <= res_r[0];
            out_b_r[0]  <= res_r[1];
            out_t_r[1]  <= res_r[2];
            out_b_r[1]  <= res_r[3];
            out_t_r[2]  <= res_r[4];
            out_b_r[2]  <= neg_r ? -mag32 : mag32;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tangent_x   = out_t_r[0];
  assign out_tangent_y   = out_t_r[1];
  assign out_tangent_z   = out_t_r[2];
  assign out_bitangent_x = out_b_r[0];
  assign out_bitangent_y = out_b_r[1];
  assign out_bitangent_z = out_b_r[2];
  assign out_degenerate  = out_deg_r;

  `TTB_ASSERT(a_close_blocked, !(in_ready && slot_r[1] && out_valid_r),
              "closing vertex taken over pending word")
  `TTB_ASSERT_IMP(a_busy_not_ready, st_r != ST_IDLE, !in_ready, "ready while sequencer busy")
  `TTB_ASSERT_IMP(a_rem_bound, st_r == ST_DIV || st_r == ST_DFIN, rem_r < dmag_r,
                  "divider remainder out of range")
  `TTB_ASSERT_IMP(a_deg_zero, out_valid_r && out_deg_r,
                  out_t_r[0] == '0 && out_b_r[2] == '0, "degenerate word with nonzero vector")
endmodule
